// ----- rtl/ttlm_pkg.sv -----
// ---------------------------------------------------------------------------
// ttlm_pkg: shared types and constants of the task time and load monitor.
// Event kinds, result codes, payload structs and the sequencer state type.
// ---------------------------------------------------------------------------
package ttlm_pkg;

	typedef enum logic [1:0] {
		KIND_START = 2'd0,
		KIND_ENTRY = 2'd1,
		KIND_EXIT  = 2'd2,
		KIND_CHECK = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IGNORED = 3'd0,
		ST_STARTED = 3'd1,
		ST_ENTRY   = 3'd2,
		ST_EXIT    = 3'd3,
		ST_OPEN    = 3'd4,
		ST_CLOSED  = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		REG_TICKS_PER_US   = 2'd0,
		REG_WINDOW_TICKS   = 2'd1,
		REG_BUSY_TASK_LAST = 2'd2
	} reg_index_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_READ,
		S_EXIT_DIV,
		S_EXIT_WB,
		S_LOAD_MUL,
		S_LOAD_DIV,
		S_SUM_CLEAR,
		S_OUT
	} state_t;

	localparam logic [15:0] LOAD_FULL = 16'd10000;
	localparam logic [15:0] LOAD_SAT  = 16'hFFFF;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  task_slot;
		logic [31:0] timestamp;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] elapsed_us;
		logic [31:0] max_us;
		logic [31:0] min_us;
		logic [31:0] avg_us;
		logic [31:0] sum_us;
		logic [15:0] load_now;
		logic [15:0] load_max;
		logic [15:0] load_min;
		logic [15:0] load_avg;
	} out_item_t;

endpackage

// ----- rtl/task_time_and_load_monitor_top.sv -----
// ---------------------------------------------------------------------------
// task_time_and_load_monitor_top
// Per-slot task run time statistics and windowed load, kept in slot memory.
// ---------------------------------------------------------------------------
// Usage: events enter on the in channel (valid/ready) as kind, task slot and
// timestamp; each event yields exactly one result on the out channel. A
// register write channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets
// ticks_per_us, window_ticks and busy_task_last; the user must write them
// only while the block is idle, which the block itself does not enforce.
// One event is handled at a time; the next event is taken only after the
// result has been transferred. Events before the first start and repeated
// starts go straight to the output; entries, other ignored events and open
// window checks pass through the read state first. An exit event runs the
// 32-step restoring divider that turns ticks into microseconds, then the
// read-modify-write of the slot memory. A closing window check runs a
// multiply, a 48-step division for the load, then a read-write pass over
// the slot memory that clears the window sums. A first start clears the
// statistics memory. After reset the block accepts events at once.
// The result is held in an output register; while the receiver stalls,
// the block accepts no new event, and the result stays unchanged until
// its transfer.
// ---------------------------------------------------------------------------
module task_time_and_load_monitor_top #(
	parameter int TASK_SLOTS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ttlm_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ttlm_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	localparam int AW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam logic [AW:0] LAST = (AW+1)'(TASK_SLOTS - 1);
	localparam logic [AW:0] SLOTS_N = (AW+1)'(TASK_SLOTS);

	// Slot statistics memory: max, min, avg, sum.
	logic [127:0] stat_mem [TASK_SLOTS];
	logic [31:0]  stamp_mem [TASK_SLOTS];
	logic [127:0] stat_rd_q;
	logic [31:0]  stamp_rd_q;
	logic [TASK_SLOTS-1:0] valid_q;

	logic [7:0]  tpu_q;
	logic [31:0] win_q;
	logic [3:0]  btl_q;

	ttlm_pkg::state_t state_q, state_d;
	ttlm_pkg::in_item_t item_q;
	logic        started_q;
	logic [31:0] busy_q, wbegin_q;
	logic [15:0] lpeak_q, lfloor_q, lmean_q;
	logic [AW:0] cnt_q;
	logic [5:0]  step_q;
	logic [47:0] num_q;
	logic [47:0] rem_q;
	logic [31:0] den_q;
	logic [31:0] dt_q;
	ttlm_pkg::out_item_t out_q;
	logic        out_valid_q;

	logic [AW-1:0] slot_a;
	logic [AW-1:0] rd_addr;
	logic          slot_ok;
	logic [31:0]   len;
	logic [48:0]   trial;
	logic          mem_we, stamp_we;
	logic [AW-1:0] mem_addr;
	logic [127:0]  mem_wd;
	logic [31:0]   us, nmax, nmin, navg, nsum;
	logic [32:0]   avg_sum;
	logic [15:0]   load;
	logic [16:0]   lavg_sum;

	assign slot_a   = AW'(item_q.task_slot);
	assign slot_ok  = {5'd0, item_q.task_slot} < 9'(TASK_SLOTS);
	assign len      = item_q.timestamp - wbegin_q;
	assign in_ready = (state_q == ttlm_pkg::S_IDLE) && !out_valid_q;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// One bit of restoring division per step.
	assign trial = {rem_q, num_q[47]} - {17'd0, den_q};

	assign us = num_q[31:0];
	assign nmax = (stat_rd_q[127:96] < us) ? us : stat_rd_q[127:96];
	assign nmin = (stat_rd_q[95:64] > us) ? us : stat_rd_q[95:64];
	assign avg_sum = {1'b0, stat_rd_q[63:32]} + {1'b0, us};
	assign navg = (stat_rd_q[63:32] == 32'd0) ? us : avg_sum[32:1];
	assign nsum = stat_rd_q[31:0] + us;
	assign load = (num_q[47:16] != 32'd0) ? ttlm_pkg::LOAD_SAT : num_q[15:0];
	assign lavg_sum = {1'b0, lmean_q} + {1'b0, load};

	// The slot rows are read at the input transfer so they are ready in S_READ.
	always_comb begin
		case (state_q)
			ttlm_pkg::S_IDLE:      rd_addr = AW'(in_data.task_slot);
			ttlm_pkg::S_SUM_CLEAR: rd_addr = cnt_q[AW-1:0];
			default:               rd_addr = slot_a;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ttlm_pkg::S_IDLE: begin
				if (in_valid && in_ready) begin
					case (in_data.kind)
						ttlm_pkg::KIND_START:
							state_d = started_q ? ttlm_pkg::S_OUT : ttlm_pkg::S_CLEAR;
						default:
							state_d = started_q ? ttlm_pkg::S_READ : ttlm_pkg::S_OUT;
					endcase
				end
			end
			ttlm_pkg::S_CLEAR:
				if (cnt_q == LAST) state_d = ttlm_pkg::S_OUT;
			ttlm_pkg::S_READ: begin
				case (item_q.kind)
					ttlm_pkg::KIND_EXIT:
						state_d = (slot_ok && valid_q[slot_a]) ?
							ttlm_pkg::S_EXIT_DIV : ttlm_pkg::S_OUT;
					ttlm_pkg::KIND_CHECK:
						state_d = (len < win_q) ? ttlm_pkg::S_OUT : ttlm_pkg::S_LOAD_MUL;
					default: state_d = ttlm_pkg::S_OUT;
				endcase
			end
			ttlm_pkg::S_EXIT_DIV:
				if (step_q == 6'd31) state_d = ttlm_pkg::S_EXIT_WB;
			ttlm_pkg::S_EXIT_WB:   state_d = ttlm_pkg::S_OUT;
			ttlm_pkg::S_LOAD_MUL:  state_d = ttlm_pkg::S_LOAD_DIV;
			ttlm_pkg::S_LOAD_DIV:
				if (step_q == 6'd47) state_d = ttlm_pkg::S_SUM_CLEAR;
			ttlm_pkg::S_SUM_CLEAR:
				if (cnt_q == SLOTS_N) state_d = ttlm_pkg::S_OUT;
			ttlm_pkg::S_OUT:
				state_d = ttlm_pkg::S_IDLE;
			default: state_d = ttlm_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		mem_we   = 1'b0;
		mem_addr = slot_a;
		mem_wd   = {nmax, nmin, navg, nsum};
		stamp_we = 1'b0;
		case (state_q)
			ttlm_pkg::S_CLEAR: begin
				mem_we   = 1'b1;
				mem_addr = cnt_q[AW-1:0];
				mem_wd   = {32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0};
			end
			ttlm_pkg::S_READ:
				stamp_we = (item_q.kind == ttlm_pkg::KIND_ENTRY) && slot_ok;
			ttlm_pkg::S_EXIT_WB:
				mem_we = 1'b1;
			ttlm_pkg::S_SUM_CLEAR: begin
				// Each row is written back with a zero sum in the cycle after its read.
				mem_addr = AW'(cnt_q - 1'b1);
				mem_we   = (cnt_q != '0);
				mem_wd   = {stat_rd_q[127:32], 32'd0};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) stat_mem[mem_addr] <= mem_wd;
		if (stamp_we) stamp_mem[slot_a] <= item_q.timestamp;
		stat_rd_q  <= stat_mem[rd_addr];
		stamp_rd_q <= stamp_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpu_q <= 8'd40;
			win_q <= 32'd8000000;
			btl_q <= 4'd15;
		end else if (cfg_valid) begin
			case (cfg_index)
				ttlm_pkg::REG_TICKS_PER_US:   tpu_q <= cfg_data[7:0];
				ttlm_pkg::REG_WINDOW_TICKS:   win_q <= cfg_data;
				ttlm_pkg::REG_BUSY_TASK_LAST: btl_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ttlm_pkg::S_IDLE;
			started_q   <= 1'b0;
			valid_q     <= '0;
			busy_q      <= '0;
			wbegin_q    <= '0;
			lpeak_q     <= '0;
			lfloor_q    <= ttlm_pkg::LOAD_FULL;
			lmean_q     <= '0;
			cnt_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ttlm_pkg::S_IDLE: begin
					cnt_q <= '0;
					if (in_valid && in_ready) begin
						item_q <= in_data;
						out_q  <= '0;
					end
				end
				ttlm_pkg::S_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST) begin
						started_q <= 1'b1;
						valid_q   <= '0;
						busy_q    <= '0;
						lpeak_q   <= '0;
						lfloor_q  <= ttlm_pkg::LOAD_FULL;
						lmean_q   <= '0;
						wbegin_q  <= item_q.timestamp;
						out_q.status <= ttlm_pkg::ST_STARTED;
					end
				end
				ttlm_pkg::S_READ: begin
					step_q <= '0;
					case (item_q.kind)
						ttlm_pkg::KIND_ENTRY:
							if (slot_ok) begin
								valid_q[slot_a] <= 1'b1;
								out_q.status    <= ttlm_pkg::ST_ENTRY;
							end
						ttlm_pkg::KIND_EXIT:
							if (slot_ok && valid_q[slot_a]) begin
								dt_q  <= item_q.timestamp - stamp_rd_q;
								num_q <= {item_q.timestamp - stamp_rd_q, 16'd0};
								rem_q <= '0;
								den_q <= (tpu_q == 8'd0) ? 32'd1 : {24'd0, tpu_q};
								valid_q[slot_a] <= 1'b0;
							end
						ttlm_pkg::KIND_CHECK: begin
							out_q.status <= (len < win_q) ? ttlm_pkg::ST_OPEN :
								ttlm_pkg::ST_CLOSED;
							out_q.load_max <= lpeak_q;
							out_q.load_min <= lfloor_q;
							out_q.load_avg <= lmean_q;
							den_q <= (len == 32'd0) ? 32'd1 : len;
							rem_q <= '0;
						end
						default: ;
					endcase
				end
				ttlm_pkg::S_EXIT_DIV, ttlm_pkg::S_LOAD_DIV: begin
					step_q <= step_q + 1'b1;
					if (!trial[48]) begin
						rem_q <= trial[47:0];
						num_q <= {num_q[46:0], 1'b1};
					end else begin
						rem_q <= {rem_q[46:0], num_q[47]};
						num_q <= {num_q[46:0], 1'b0};
					end
				end
				ttlm_pkg::S_EXIT_WB: begin
					if ({1'b0, item_q.task_slot} <= {1'b0, btl_q}) busy_q <= busy_q + dt_q;
					out_q.status     <= ttlm_pkg::ST_EXIT;
					out_q.elapsed_us <= us;
					out_q.max_us     <= nmax;
					out_q.min_us     <= nmin;
					out_q.avg_us     <= navg;
					out_q.sum_us     <= nsum;
				end
				ttlm_pkg::S_LOAD_MUL: begin
					num_q  <= busy_q * 48'(ttlm_pkg::LOAD_FULL);
					step_q <= '0;
				end
				ttlm_pkg::S_SUM_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == '0) begin
						wbegin_q <= item_q.timestamp;
						busy_q   <= '0;
						if (lpeak_q < load) begin
							lpeak_q <= load;
							out_q.load_max <= load;
						end else out_q.load_max <= lpeak_q;
						if (lfloor_q > load) begin
							lfloor_q <= load;
							out_q.load_min <= load;
						end else out_q.load_min <= lfloor_q;
						lmean_q <= (lmean_q == 16'd0) ? load : lavg_sum[16:1];
						out_q.load_avg <= (lmean_q == 16'd0) ? load : lavg_sum[16:1];
						out_q.load_now <= load;
					end
				end
				ttlm_pkg::S_OUT:
					out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

endmodule

// ----- bench/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the task time and load monitor.
// Directed and random event streams are checked against a local predictor of
// slot run time statistics and window load, with random idling on both sides.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

	localparam int NSLOT = 16;
	localparam int CYCLE_LIMIT = 1500000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	ttlm_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	ttlm_pkg::out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	task_time_and_load_monitor_top #(.TASK_SLOTS(NSLOT)) uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Predictor state.
	logic [7:0] p_tpu;
	logic [31:0] p_win;
	logic [3:0] p_busy_last;
	bit p_started;
	logic [31:0] p_stamp [NSLOT];
	bit p_valid [NSLOT];
	logic [31:0] p_max [NSLOT], p_min [NSLOT], p_avg [NSLOT], p_sum [NSLOT];
	logic [31:0] p_busy, p_wbegin;
	logic [15:0] p_lpeak, p_lfloor, p_lmean;

	ttlm_pkg::in_item_t event_queue [$];
	ttlm_pkg::out_item_t result_queue [$];
	int errors = 0;
	int cycles = 0;
	int in_idle_pct = 0, out_idle_pct = 0;
	int hold_off = 0;
	int n_exits = 0, n_closes = 0;
	logic [31:0] now_ts;
	bit stamp_known [NSLOT];

	function automatic logic [31:0] halve32(logic [31:0] old, logic [31:0] nw);
		logic [32:0] s;
		if (old == 0) return nw;
		s = {1'b0, old} + {1'b0, nw};
		return s[32:1];
	endfunction

	function automatic void clear_predictor();
		for (int i = 0; i < NSLOT; i++) begin
			p_valid[i] = 0; p_max[i] = 0; p_min[i] = '1; p_avg[i] = 0; p_sum[i] = 0;
		end
		p_busy = 0; p_lpeak = 0; p_lfloor = ttlm_pkg::LOAD_FULL; p_lmean = 0;
	endfunction

	function automatic ttlm_pkg::out_item_t predict_event(ttlm_pkg::in_item_t it);
		ttlm_pkg::out_item_t r;
		logic [31:0] dt, us, len, div;
		logic [63:0] q;
		logic [15:0] ld;
		int s;
		r = '0;
		r.status = ttlm_pkg::ST_IGNORED;
		s = int'(it.task_slot);
		if (it.kind == ttlm_pkg::KIND_START) begin
			if (!p_started) begin
				clear_predictor();
				p_wbegin = it.timestamp;
				p_started = 1;
				r.status = ttlm_pkg::ST_STARTED;
			end
		end else if (p_started) begin
			if (it.kind == ttlm_pkg::KIND_ENTRY) begin
				p_stamp[s] = it.timestamp;
				p_valid[s] = 1;
				r.status = ttlm_pkg::ST_ENTRY;
			end else if (it.kind == ttlm_pkg::KIND_EXIT) begin
				if (p_valid[s]) begin
					div = (p_tpu == 0) ? 32'd1 : {24'd0, p_tpu};
					dt = it.timestamp - p_stamp[s];
					us = dt / div;
					p_valid[s] = 0;
					if (p_max[s] < us) p_max[s] = us;
					if (p_min[s] > us) p_min[s] = us;
					p_avg[s] = halve32(p_avg[s], us);
					p_sum[s] = p_sum[s] + us;
					if (s <= int'(p_busy_last)) p_busy = p_busy + dt;
					r.status = ttlm_pkg::ST_EXIT;
					r.elapsed_us = us; r.max_us = p_max[s]; r.min_us = p_min[s];
					r.avg_us = p_avg[s]; r.sum_us = p_sum[s];
				end
			end else begin
				len = it.timestamp - p_wbegin;
				if (len < p_win) begin
					r.status = ttlm_pkg::ST_OPEN;
				end else begin
					q = ({32'd0, p_busy} * 64'd10000) / ((len == 0) ? 64'd1 : {32'd0, len});
					ld = (q > 64'hFFFF) ? ttlm_pkg::LOAD_SAT : q[15:0];
					p_wbegin = it.timestamp;
					p_busy = 0;
					for (int i = 0; i < NSLOT; i++) p_sum[i] = 0;
					if (p_lpeak < ld) p_lpeak = ld;
					if (p_lfloor > ld) p_lfloor = ld;
					p_lmean = 16'(halve32({16'd0, p_lmean}, {16'd0, ld}));
					r.status = ttlm_pkg::ST_CLOSED;
					r.load_now = ld;
				end
				r.load_max = p_lpeak; r.load_min = p_lfloor; r.load_avg = p_lmean;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("MISMATCH %s: got %0h expected %0h", field, got, want);
	endtask

	// Driver: offers the oldest pending event; predicts on transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				result_queue.push_back(predict_event(in_data));
				void'(event_queue.pop_front());
			end
			if ((!in_valid || in_ready) ) begin
				if (in_valid && in_ready && event_queue.size() > 0 &&
				    $urandom_range(99) >= in_idle_pct) begin
					in_data <= event_queue[0];
				end else if (in_valid && in_ready) begin
					in_valid <= 1'b0;
				end else if (event_queue.size() > 0 &&
				             $urandom_range(99) >= in_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= event_queue[0];
				end
			end
		end
	end

	// Monitor: compares each result transfer with the oldest expectation.
	always @(posedge clk) begin
		ttlm_pkg::out_item_t w;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (result_queue.size() == 0) begin
					report_mismatch("unexpected result status", 32'(out_data.status), 32'd0);
				end else begin
					w = result_queue.pop_front();
					if (w.status == ttlm_pkg::ST_EXIT) n_exits++;
					if (w.status == ttlm_pkg::ST_CLOSED) n_closes++;
					if (out_data.status !== w.status)
						report_mismatch("status", 32'(out_data.status), 32'(w.status));
					if (out_data.elapsed_us !== w.elapsed_us)
						report_mismatch("elapsed_us", out_data.elapsed_us, w.elapsed_us);
					if (out_data.max_us !== w.max_us)
						report_mismatch("max_us", out_data.max_us, w.max_us);
					if (out_data.min_us !== w.min_us)
						report_mismatch("min_us", out_data.min_us, w.min_us);
					if (out_data.avg_us !== w.avg_us)
						report_mismatch("avg_us", out_data.avg_us, w.avg_us);
					if (out_data.sum_us !== w.sum_us)
						report_mismatch("sum_us", out_data.sum_us, w.sum_us);
					if (out_data.load_now !== w.load_now)
						report_mismatch("load_now", 32'(out_data.load_now), 32'(w.load_now));
					if (out_data.load_max !== w.load_max)
						report_mismatch("load_max", 32'(out_data.load_max), 32'(w.load_max));
					if (out_data.load_min !== w.load_min)
						report_mismatch("load_min", 32'(out_data.load_min), 32'(w.load_min));
					if (out_data.load_avg !== w.load_avg)
						report_mismatch("load_avg", 32'(out_data.load_avg), 32'(w.load_avg));
				end
			end
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= out_idle_pct);
			end
		end
	end

	task automatic write_reg(ttlm_pkg::reg_index_t idx, logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			ttlm_pkg::REG_TICKS_PER_US: p_tpu = val[7:0];
			ttlm_pkg::REG_WINDOW_TICKS: p_win = val;
			default: p_busy_last = val[3:0];
		endcase
	endtask

	task automatic drain();
		while (event_queue.size() > 0 || result_queue.size() > 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic ttlm_pkg::in_item_t mk(ttlm_pkg::kind_t k, logic [3:0] s,
	                                          logic [31:0] ts);
		ttlm_pkg::in_item_t it;
		it.kind = k; it.task_slot = s; it.timestamp = ts;
		return it;
	endfunction

	// Queues a random event; mostly well-formed entry/exit pairs on advancing time.
	task automatic queue_random_event();
		logic [3:0] s;
		int pick;
		s = 4'($urandom_range(NSLOT - 1));
		pick = $urandom_range(99);
		if (pick < 3) begin
			event_queue.push_back(mk(ttlm_pkg::KIND_START, s, $urandom));
		end else if (pick < 12) begin
			now_ts = now_ts + $urandom_range(40000);
			event_queue.push_back(mk(ttlm_pkg::KIND_CHECK, s, now_ts));
		end else if (pick < 16) begin
			// Raw noise: a random-time exit on a slot that may have no open entry, else a random-time entry.
			if (stamp_known[s]) event_queue.push_back(mk(ttlm_pkg::KIND_EXIT, s, $urandom));
			else event_queue.push_back(mk(ttlm_pkg::KIND_ENTRY, s, $urandom));
			stamp_known[s] = 1;
		end else begin
			now_ts = now_ts + $urandom_range(2000);
			event_queue.push_back(mk(ttlm_pkg::KIND_ENTRY, s, now_ts));
			stamp_known[s] = 1;
			now_ts = now_ts + (($urandom_range(9) == 0) ? $urandom : $urandom_range(30000));
			event_queue.push_back(mk(ttlm_pkg::KIND_EXIT, s, now_ts));
		end
	endtask

	initial begin
		p_tpu = 8'd40; p_win = 32'd8000000; p_busy_last = 4'd15;
		p_started = 0; p_wbegin = 0;
		clear_predictor();
		for (int i = 0; i < NSLOT; i++) stamp_known[i] = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: events before start, then start and the corner cases.
		event_queue.push_back(mk(ttlm_pkg::KIND_ENTRY, 4'd3, 32'd100));
		event_queue.push_back(mk(ttlm_pkg::KIND_EXIT, 4'd3, 32'd200));
		event_queue.push_back(mk(ttlm_pkg::KIND_CHECK, 4'd0, 32'd300));
		drain();
		write_reg(ttlm_pkg::REG_TICKS_PER_US, 32'd0);
		write_reg(ttlm_pkg::REG_WINDOW_TICKS, 32'd0);
		write_reg(ttlm_pkg::REG_BUSY_TASK_LAST, 32'd0);
		event_queue.push_back(mk(ttlm_pkg::KIND_START, 4'd0, 32'hFFFF_FF00));
		event_queue.push_back(mk(ttlm_pkg::KIND_START, 4'd5, 32'd0));
		event_queue.push_back(mk(ttlm_pkg::KIND_EXIT, 4'd7, 32'd10));
		event_queue.push_back(mk(ttlm_pkg::KIND_ENTRY, 4'd0, 32'hFFFF_FFF0));
		event_queue.push_back(mk(ttlm_pkg::KIND_EXIT, 4'd0, 32'h0000_0010));
		event_queue.push_back(mk(ttlm_pkg::KIND_ENTRY, 4'd15, 32'd0));
		event_queue.push_back(mk(ttlm_pkg::KIND_EXIT, 4'd15, 32'hFFFF_FFFF));
		event_queue.push_back(mk(ttlm_pkg::KIND_EXIT, 4'd15, 32'd5));
		event_queue.push_back(mk(ttlm_pkg::KIND_CHECK, 4'd0, 32'hFFFF_FF00));
		event_queue.push_back(mk(ttlm_pkg::KIND_CHECK, 4'd0, 32'hFFFF_FF01));
		event_queue.push_back(mk(ttlm_pkg::KIND_ENTRY, 4'd0, 32'd1000));
		event_queue.push_back(mk(ttlm_pkg::KIND_EXIT, 4'd0, 32'd1000));
		event_queue.push_back(mk(ttlm_pkg::KIND_ENTRY, 4'd0, 32'd0));
		event_queue.push_back(mk(ttlm_pkg::KIND_EXIT, 4'd0, 32'hFFFF_0000));
		event_queue.push_back(mk(ttlm_pkg::KIND_CHECK, 4'd9, 32'hFFFF_0001));
		drain();
		write_reg(ttlm_pkg::REG_TICKS_PER_US, 32'd255);
		write_reg(ttlm_pkg::REG_WINDOW_TICKS, 32'hFFFF_FFFF);
		write_reg(ttlm_pkg::REG_BUSY_TASK_LAST, 32'd15);
		event_queue.push_back(mk(ttlm_pkg::KIND_ENTRY, 4'd1, 32'd0));
		event_queue.push_back(mk(ttlm_pkg::KIND_EXIT, 4'd1, 32'hFFFF_FFFE));
		event_queue.push_back(mk(ttlm_pkg::KIND_CHECK, 4'd1, 32'd5));
		drain();

		now_ts = $urandom;
		for (int ph = 0; ph < 3; ph++) begin
			in_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 73 : 0;
			out_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 24 : 0;
			write_reg(ttlm_pkg::REG_TICKS_PER_US, (ph == 2) ? 32'd1 : $urandom_range(1, 255));
			write_reg(ttlm_pkg::REG_WINDOW_TICKS,
			          (ph == 1) ? 32'd1 : $urandom_range(20000, 400000));
			write_reg(ttlm_pkg::REG_BUSY_TASK_LAST, $urandom_range(15));
			if (ph == 0) begin
				for (int i = 0; i < 20; i++) queue_random_event();
				hold_off = 400;
			end
			while (event_queue.size() < 500) queue_random_event();
			drain();
		end

		$display("Covered %0d slot exits and %0d closed windows over three pacing phases.",
		         n_exits, n_closes);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
